@@ hw/rtl/rmbe_pkg.sv @@
// rmbe_pkg: shared types, codes and the rotation helper for the blit expander
// no dependencies; imported by all rmbe modules
package rmbe_pkg;

    // operation code carried by a request
    typedef enum logic {
        OP_WINDOW = 1'b0,
        OP_PIXEL  = 1'b1
    } t_op;

    // clockwise quarter turns
    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_FG_COLOR    = 3'd0,
        CFG_BG_COLOR    = 3'd1,
        CFG_ROTATION    = 3'd2,
        CFG_VIRT_WIDTH  = 3'd3,
        CFG_VIRT_HEIGHT = 3'd4
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // one request as held in the input register
    typedef struct packed {
        t_op         op;
        logic [9:0]  win_x;
        logic [9:0]  win_y;
        logic [10:0] win_w;
        logic [10:0] win_h;
        logic        pix_bit;
    } t_req;

    // one response as held in the result register
    typedef struct packed {
        logic        win_error;
        logic [9:0]  corner_x0;
        logic [9:0]  corner_y0;
        logic [9:0]  corner_x1;
        logic [9:0]  corner_y1;
        logic [19:0] pixel_index;
        logic [15:0] pixel_color;
        logic        pixel_write;
        logic        last_pixel;
    } t_rsp;

    // blit state kept between requests
    typedef struct packed {
        logic [10:0] blit_w;
        logic [10:0] blit_h;
        logic [9:0]  src_col;
        logic [10:0] src_row;
        logic [19:0] pixel_seq;
        logic        window_bad;
        logic        buffered;
    } t_blit_state;

    // window decode result
    typedef struct packed {
        logic        bad;
        logic [9:0]  x0;
        logic [9:0]  y0;
        logic [9:0]  x1;
        logic [9:0]  y1;
        logic [10:0] blit_w;
        logic [10:0] blit_h;
        logic        buffered;
    } t_win_res;

    // pixel decode result
    typedef struct packed {
        logic        active;
        logic [19:0] index;
        logic [15:0] color;
        logic        write;
        logic        last;
        logic [9:0]  n_col;
        logic [10:0] n_row;
        logic [19:0] n_seq;
    } t_pix_res;

    typedef struct packed {
        logic [10:0] rx;
        logic [10:0] ry;
    } t_point;

    // rotate (x, y) inside a w-by-h area, x < w and y < h
    function automatic t_point rot_point(input t_rot rot, input logic [10:0] x,
                                         input logic [10:0] y, input logic [10:0] w,
                                         input logic [10:0] h);
        t_point p;
        unique case (rot)
            ROT_90: begin
                p.rx = y;
                p.ry = w - x - 11'd1;
            end
            ROT_180: begin
                p.rx = w - x - 11'd1;
                p.ry = h - y - 11'd1;
            end
            ROT_270: begin
                p.rx = h - y - 11'd1;
                p.ry = x;
            end
            default: begin
                p.rx = x;
                p.ry = y;
            end
        endcase
        return p;
    endfunction

endpackage

@@ hw/rtl/rmbe_req_if.sv @@
// rmbe_req_if: request channel of the blit expander, valid/ready plus payload
// no dependencies
interface rmbe_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [9:0]  win_x;
    logic [9:0]  win_y;
    logic [10:0] win_w;
    logic [10:0] win_h;
    logic        pix_bit;

    modport source (output valid, op, win_x, win_y, win_w, win_h, pix_bit, input ready);
    modport sink   (input valid, op, win_x, win_y, win_w, win_h, pix_bit, output ready);
endinterface

@@ hw/rtl/rmbe_rsp_if.sv @@
// rmbe_rsp_if: response channel of the blit expander, valid/ready plus payload
// no dependencies
interface rmbe_rsp_if;
    logic        valid;
    logic        ready;
    logic        win_error;
    logic [9:0]  corner_x0;
    logic [9:0]  corner_y0;
    logic [9:0]  corner_x1;
    logic [9:0]  corner_y1;
    logic [19:0] pixel_index;
    logic [15:0] pixel_color;
    logic        pixel_write;
    logic        last_pixel;

    modport source (output valid, win_error, corner_x0, corner_y0, corner_x1, corner_y1,
                    pixel_index, pixel_color, pixel_write, last_pixel, input ready);
    modport sink   (input valid, win_error, corner_x0, corner_y0, corner_x1, corner_y1,
                    pixel_index, pixel_color, pixel_write, last_pixel, output ready);
endinterface

@@ hw/rtl/rmbe_win_map.sv @@
// rmbe_win_map: window clip check, corner rotation and blit size decode
// depends on rmbe_pkg
module rmbe_win_map #(
    parameter int BUF_PIXELS = 512,
    parameter int MAX_RES    = 1024
) (
    input  rmbe_pkg::t_req     i_req,
    input  rmbe_pkg::t_rot     i_rot,
    input  logic [10:0]        i_virt_w,
    input  logic [10:0]        i_virt_h,
    output rmbe_pkg::t_win_res o_res
);
    import rmbe_pkg::*;

    localparam logic [12:0] MaxResV = 13'(MAX_RES);
    localparam logic [21:0] BufPixV = 22'(BUF_PIXELS);

    logic        size_bad;
    logic        bad;
    logic [11:0] x_end;
    logic [11:0] y_end;
    t_point      pa;
    t_point      pb;
    logic [10:0] lo_x, hi_x, lo_y, hi_y;
    logic [10:0] bw, bh;
    logic [21:0] area;

    // size and bounds check
    always_comb begin
        size_bad = (i_req.win_w == 11'd0) || (i_req.win_h == 11'd0) ||
                   ({2'b00, i_req.win_w} > MaxResV) || ({2'b00, i_req.win_h} > MaxResV);
        x_end    = {2'b00, i_req.win_x} + {1'b0, i_req.win_w} - 12'd1;
        y_end    = {2'b00, i_req.win_y} + {1'b0, i_req.win_h} - 12'd1;
        bad      = size_bad || (x_end >= {1'b0, i_virt_w}) || (y_end >= {1'b0, i_virt_h});
    end

    // rotate both corners through the virtual area and order them
    always_comb begin
        pa   = rot_point(i_rot, {1'b0, i_req.win_x}, {1'b0, i_req.win_y}, i_virt_w, i_virt_h);
        pb   = rot_point(i_rot, x_end[10:0], y_end[10:0], i_virt_w, i_virt_h);
        lo_x = (pa.rx > pb.rx) ? pb.rx : pa.rx;
        hi_x = (pa.rx > pb.rx) ? pa.rx : pb.rx;
        lo_y = (pa.ry > pb.ry) ? pb.ry : pa.ry;
        hi_y = (pa.ry > pb.ry) ? pa.ry : pb.ry;
    end

    // stored blit size and buffer fit
    always_comb begin
        bw   = size_bad ? 11'd0 : i_req.win_w;
        bh   = size_bad ? 11'd0 : i_req.win_h;
        area = bw * bh;
    end

    always_comb begin
        o_res.bad      = bad;
        o_res.x0       = bad ? 10'd0 : lo_x[9:0];
        o_res.y0       = bad ? 10'd0 : lo_y[9:0];
        o_res.x1       = bad ? 10'd0 : hi_x[9:0];
        o_res.y1       = bad ? 10'd0 : hi_y[9:0];
        o_res.blit_w   = bw;
        o_res.blit_h   = bh;
        o_res.buffered = (area <= BufPixV);
    end

endmodule

@@ hw/rtl/rmbe_pix_map.sv @@
// rmbe_pix_map: color expansion, rotated buffer index and pixel counter step
// depends on rmbe_pkg
module rmbe_pix_map (
    input  logic                  i_bit,
    input  logic [15:0]           i_fg,
    input  logic [15:0]           i_bg,
    input  rmbe_pkg::t_rot        i_rot,
    input  rmbe_pkg::t_blit_state i_st,
    output rmbe_pkg::t_pix_res    o_res
);
    import rmbe_pkg::*;

    logic        active;
    t_point      p;
    logic [10:0] stride;
    logic [21:0] buf_idx;
    logic [10:0] col_inc;
    logic [10:0] row_inc;

    // position inside the rotated w-by-h buffer
    always_comb begin
        active  = (i_st.blit_w != 11'd0) && (i_st.src_row < i_st.blit_h);
        p       = rot_point(i_rot, {1'b0, i_st.src_col}, i_st.src_row,
                            i_st.blit_w, i_st.blit_h);
        stride  = i_rot[0] ? i_st.blit_h : i_st.blit_w;
        buf_idx = (p.ry * stride) + 22'(p.rx);
        col_inc = {1'b0, i_st.src_col} + 11'd1;
        row_inc = i_st.src_row + 11'd1;
    end

    // result fields, zero for a surplus pixel
    always_comb begin
        o_res.active = active;
        o_res.index  = '0;
        o_res.color  = '0;
        o_res.write  = 1'b0;
        o_res.last   = 1'b0;
        if (active) begin
            o_res.index = i_st.buffered ? buf_idx[19:0] : i_st.pixel_seq;
            o_res.color = i_bit ? i_fg : i_bg;
            o_res.write = i_st.buffered || !i_st.window_bad;
            o_res.last  = (col_inc == i_st.blit_w) && (row_inc == i_st.blit_h);
        end
    end

    // raster counter step
    always_comb begin
        o_res.n_seq = i_st.pixel_seq + 20'd1;
        if (col_inc >= i_st.blit_w) begin
            o_res.n_col = '0;
            o_res.n_row = row_inc;
        end else begin
            o_res.n_col = col_inc[9:0];
            o_res.n_row = i_st.src_row;
        end
    end

endmodule

@@ hw/rtl/rotated_mono_blit_expander.sv @@
// Usage
// Requests arrive on i_req (valid/ready). A window request (op 0) carries
// win_x, win_y, win_w, win_h; a pixel request (op 1) carries one glyph bit.
// Every request yields exactly one response on o_rsp (valid/ready): a window
// response gives win_error and the ordered, rotated corners; a pixel response
// gives pixel_index, pixel_color, pixel_write and last_pixel.
// The input register feeds the decode, which loads the result register once
// that register is free; the response is then valid on o_rsp.
// Throughput is one request per cycle while the receiver does not stall;
// a pixel request needs one 11x11 multiply and the counter step, a window
// request the clip compares, the corner rotation and one 11x11 multiply, all
// between the input and result registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; after that i_req.ready falls until the
// response is taken.
// Reset (synchronous, active low) empties both registers, clears the blit
// state and restores the color, rotation and resolution registers. Write the
// configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) only while idle.
// Depends on rmbe_pkg, rmbe_req_if, rmbe_rsp_if, rmbe_win_map, rmbe_pix_map.
module rotated_mono_blit_expander #(
    parameter int BUF_PIXELS = 512,
    parameter int MAX_RES    = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rmbe_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rmbe_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    rmbe_req_if.sink                            i_req,
    rmbe_rsp_if.source                          o_rsp
);
    import rmbe_pkg::*;

    logic [15:0] r_fg_color;
    logic [15:0] r_bg_color;
    t_rot        r_rotation;
    logic [10:0] r_virt_w;
    logic [10:0] r_virt_h;

    logic        r_in_vld;
    t_req        r_in;
    logic        r_out_vld;
    t_rsp        r_out;
    t_blit_state r_st;
    t_blit_state n_st;
    t_rsp        n_out;

    logic        advance;
    logic        req_take;
    t_win_res    win_res;
    t_pix_res    pix_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_color <= 16'hFFFF;
            r_bg_color <= 16'h0000;
            r_rotation <= ROT_0;
            r_virt_w   <= 11'd320;
            r_virt_h   <= 11'd240;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FG_COLOR:    r_fg_color <= i_cfg_data;
                CFG_BG_COLOR:    r_bg_color <= i_cfg_data;
                CFG_ROTATION:    r_rotation <= t_rot'(i_cfg_data[1:0]);
                CFG_VIRT_WIDTH:  r_virt_w   <= i_cfg_data[10:0];
                CFG_VIRT_HEIGHT: r_virt_h   <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // handshake: the input register moves on when the result register is free
    assign advance     = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = i_rst_n && (!r_in_vld || advance);
    assign req_take    = i_req.valid && i_req.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (req_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_in.op      <= t_op'(i_req.op);
            r_in.win_x   <= i_req.win_x;
            r_in.win_y   <= i_req.win_y;
            r_in.win_w   <= i_req.win_w;
            r_in.win_h   <= i_req.win_h;
            r_in.pix_bit <= i_req.pix_bit;
        end
    end

    rmbe_win_map #(
        .BUF_PIXELS (BUF_PIXELS),
        .MAX_RES    (MAX_RES)
    ) u_win_map (
        .i_req    (r_in),
        .i_rot    (r_rotation),
        .i_virt_w (r_virt_w),
        .i_virt_h (r_virt_h),
        .o_res    (win_res)
    );

    rmbe_pix_map u_pix_map (
        .i_bit (r_in.pix_bit),
        .i_fg  (r_fg_color),
        .i_bg  (r_bg_color),
        .i_rot (r_rotation),
        .i_st  (r_st),
        .o_res (pix_res)
    );

    // response and next blit state
    always_comb begin
        n_out = '0;
        n_st  = r_st;
        if (r_in.op == OP_WINDOW) begin
            n_out.win_error = win_res.bad;
            n_out.corner_x0 = win_res.x0;
            n_out.corner_y0 = win_res.y0;
            n_out.corner_x1 = win_res.x1;
            n_out.corner_y1 = win_res.y1;
            n_st.blit_w     = win_res.blit_w;
            n_st.blit_h     = win_res.blit_h;
            n_st.src_col    = '0;
            n_st.src_row    = '0;
            n_st.pixel_seq  = '0;
            n_st.window_bad = win_res.bad;
            n_st.buffered   = win_res.buffered;
        end else begin
            n_out.pixel_index = pix_res.index;
            n_out.pixel_color = pix_res.color;
            n_out.pixel_write = pix_res.write;
            n_out.last_pixel  = pix_res.last;
            if (pix_res.active) begin
                n_st.src_col   = pix_res.n_col;
                n_st.src_row   = pix_res.n_row;
                n_st.pixel_seq = pix_res.n_seq;
            end
        end
    end

    // blit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (advance) begin
            r_st <= n_st;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.win_error   = r_out.win_error;
    assign o_rsp.corner_x0   = r_out.corner_x0;
    assign o_rsp.corner_y0   = r_out.corner_y0;
    assign o_rsp.corner_x1   = r_out.corner_x1;
    assign o_rsp.corner_y1   = r_out.corner_y1;
    assign o_rsp.pixel_index = r_out.pixel_index;
    assign o_rsp.pixel_color = r_out.pixel_color;
    assign o_rsp.pixel_write = r_out.pixel_write;
    assign o_rsp.last_pixel  = r_out.last_pixel;

`ifndef NO_ASSERTIONS
    // blit width and height are zeroed together
    a_size_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.blit_w == 11'd0) |-> (r_st.blit_h == 11'd0))
        else $error("blit width zero with nonzero height");

    // the row counter never passes the blit height
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.src_row <= r_st.blit_h)
        else $error("source row beyond blit height");

    // the column counter stays inside the blit width
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.blit_w != 11'd0) |-> ({1'b0, r_st.src_col} < r_st.blit_w))
        else $error("source column beyond blit width");

    // a request leaving the input register shows up as a response
    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_vld)
        else $error("advanced request lost");
`endif

endmodule
